>>> sv/smtp_seq_pkg.sv
// shared types, constants and helper functions of the smtp command sequencer
package smtp_seq_pkg;

  // longest line that is looked at; later bytes of a line are dropped
  localparam int MAX_LINE = 512;
  localparam int POS_W    = $clog2(MAX_LINE + 1);

  // character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_Z  = 8'h7A;
  localparam logic [7:0] CASE_DIFF = 8'h20;

  // reply codes
  localparam logic [9:0] RC_NONE    = 10'd0;
  localparam logic [9:0] RC_OK      = 10'd250;
  localparam logic [9:0] RC_BYE     = 10'd221;
  localparam logic [9:0] RC_DATA    = 10'd354;
  localparam logic [9:0] RC_SYNTAX  = 10'd500;
  localparam logic [9:0] RC_ARG     = 10'd501;
  localparam logic [9:0] RC_NOTIMPL = 10'd502;
  localparam logic [9:0] RC_SEQ     = 10'd503;

  // suffix lengths of RCPT and MAIL
  localparam logic [2:0] SFX_TO_LEN   = 3'd3;
  localparam logic [2:0] SFX_FROM_LEN = 3'd5;

  // verb words
  localparam logic [31:0] VERB_RCPT = "RCPT";
  localparam logic [31:0] VERB_MAIL = "MAIL";
  localparam logic [31:0] VERB_DATA = "DATA";
  localparam logic [31:0] VERB_HELO = "HELO";
  localparam logic [31:0] VERB_RSET = "RSET";
  localparam logic [31:0] VERB_QUIT = "QUIT";
  localparam logic [31:0] VERB_NOOP = "NOOP";
  localparam logic [31:0] VERB_SEND = "SEND";
  localparam logic [31:0] VERB_SOML = "SOML";
  localparam logic [31:0] VERB_SAML = "SAML";
  localparam logic [31:0] VERB_VRFY = "VRFY";
  localparam logic [31:0] VERB_EXPN = "EXPN";
  localparam logic [31:0] VERB_HELP = "HELP";
  localparam logic [31:0] VERB_TURN = "TURN";

  typedef enum logic [3:0] {
    CMD_INVALID = 4'd0,
    CMD_NOTIMPL = 4'd1,
    CMD_NOOP    = 4'd2,
    CMD_HELO    = 4'd3,
    CMD_RSET    = 4'd4,
    CMD_MAIL    = 4'd5,
    CMD_RCPT    = 4'd6,
    CMD_DATA    = 4'd7,
    CMD_QUIT    = 4'd8
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_CMD    = 2'd0,
    MODE_BODY   = 2'd1,
    MODE_CLOSED = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    PH_VERB    = 3'd0,
    PH_SEP     = 3'd1,
    PH_SPACES1 = 3'd2,
    PH_SUFFIX  = 3'd3,
    PH_SPACES2 = 3'd4,
    PH_ARG     = 3'd5,
    PH_ENDED   = 3'd6,
    PH_BAD     = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    DOT_LINE_START = 2'd0,
    DOT_IN_LINE    = 2'd1,
    DOT_HELD       = 2'd2
  } dot_t;

  // classified input item
  typedef struct packed {
    logic [7:0] ch;
    logic [7:0] up;
    logic       has_char;
    logic       line_end;
    logic       is_zero;
    logic       is_space;
    logic       is_white;
    logic       is_dot;
  } front_item_t;

  // head of the front queue as seen by the back end
  typedef struct packed {
    logic        valid;
    front_item_t item;
  } front_link_t;

  // result item
  typedef struct packed {
    logic       kind;
    logic [9:0] reply_code;
    cmd_t       command;
    logic [7:0] body_byte;
    logic       body_has_byte;
    logic       body_line_end;
  } result_t;

  // command class of an upper-cased four letter verb
  function automatic cmd_t verb_class(input logic [31:0] verb);
    cmd_t cls;
    case (verb)
      VERB_RCPT: cls = CMD_RCPT;
      VERB_MAIL: cls = CMD_MAIL;
      VERB_DATA: cls = CMD_DATA;
      VERB_HELO: cls = CMD_HELO;
      VERB_RSET: cls = CMD_RSET;
      VERB_QUIT: cls = CMD_QUIT;
      VERB_NOOP: cls = CMD_NOOP;
      VERB_SEND: cls = CMD_NOTIMPL;
      VERB_SOML: cls = CMD_NOTIMPL;
      VERB_SAML: cls = CMD_NOTIMPL;
      VERB_VRFY: cls = CMD_NOTIMPL;
      VERB_EXPN: cls = CMD_NOTIMPL;
      VERB_HELP: cls = CMD_NOTIMPL;
      VERB_TURN: cls = CMD_NOTIMPL;
      default:   cls = CMD_INVALID;
    endcase
    return cls;
  endfunction

  // expected suffix character: FROM: after MAIL, TO: otherwise
  function automatic logic [7:0] sfx_char(input logic is_mail, input logic [2:0] idx);
    logic [7:0] c;
    if (is_mail) begin
      case (idx)
        3'd0:    c = "F";
        3'd1:    c = "R";
        3'd2:    c = "O";
        3'd3:    c = "M";
        3'd4:    c = ":";
        default: c = CH_NUL;
      endcase
    end else begin
      case (idx)
        3'd0:    c = "T";
        3'd1:    c = "O";
        3'd2:    c = ":";
        default: c = CH_NUL;
      endcase
    end
    return c;
  endfunction

endpackage

>>> sv/smtp_seq_front.sv
// front end: classifies input items and holds them in a two-entry queue
module smtp_seq_front
  import smtp_seq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  in_ch,
  input  logic        in_has_char,
  input  logic        in_line_end,
  input  logic        push,
  output logic        full,
  output front_link_t head,
  input  logic        head_ready
);

  front_item_t cls_item;
  front_item_t mem_r [2];
  logic        wp_r, wp_nxt;
  logic        rp_r, rp_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        wr_en, rd_en;

  // byte classification
  always_comb begin
    cls_item.ch       = in_ch;
    cls_item.up       = (in_ch >= CH_LOW_A && in_ch <= CH_LOW_Z) ? in_ch - CASE_DIFF : in_ch;
    cls_item.has_char = in_has_char;
    cls_item.line_end = in_line_end;
    cls_item.is_zero  = (in_ch == CH_NUL);
    cls_item.is_space = (in_ch == CH_SPACE);
    cls_item.is_white = (in_ch == CH_SPACE) || (in_ch >= CH_TAB && in_ch <= CH_CR);
    cls_item.is_dot   = (in_ch == CH_DOT);
  end

  // queue pointers
  assign full       = (cnt_r == 2'd2);
  assign wr_en      = push && !full;
  assign rd_en      = head_ready && (cnt_r != 2'd0);
  assign head.valid = (cnt_r != 2'd0);
  assign head.item  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wr_en ? ~wp_r : wp_r;
    rp_nxt  = rd_en ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= cls_item;
    end
  end

endmodule

>>> sv/smtp_seq_back.sv
// back end: command parsing, session sequencing and body unstuffing
module smtp_seq_back
  import smtp_seq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  front_link_t head,
  output logic        head_ready,
  input  logic        res_room,
  output logic        res_valid,
  output result_t     res
);

  mode_t            mode_r, mode_nxt;
  logic             helo_r, helo_nxt;
  logic             sender_r, sender_nxt;
  logic             rcpt_r, rcpt_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [31:0]      verb_r, verb_nxt;
  phase_t           phase_r, phase_nxt;
  logic [2:0]       sfx_idx_r, sfx_idx_nxt;
  logic [7:0]       arg_first_r, arg_first_nxt;
  logic [7:0]       arg_last_r, arg_last_nxt;
  logic             nonempty_r, nonempty_nxt;
  logic             multi_r, multi_nxt;
  logic             nonblank_r, nonblank_nxt;
  dot_t             dot_r, dot_nxt;

  front_item_t      itm;
  logic             fire;
  logic             byte_ok;
  cmd_t             cls_cur;
  logic             needs_sfx;
  logic             do_sfx;
  logic             do_arg;
  logic [2:0]       sidx;
  logic [2:0]       sfx_len;
  logic             do_finish;
  logic             do_eod;
  cmd_t             cls_fin;
  logic             path_bad;
  logic [9:0]       code;

  assign itm        = head.item;
  assign head_ready = res_room;
  assign fire       = head.valid && res_room;
  assign cls_cur    = verb_class(verb_r);
  assign needs_sfx  = (cls_cur == CMD_MAIL) || (cls_cur == CMD_RCPT);
  assign sfx_len    = (cls_cur == CMD_MAIL) ? SFX_FROM_LEN : SFX_TO_LEN;

  // next state and result of one item
  always_comb begin
    mode_nxt      = mode_r;
    helo_nxt      = helo_r;
    sender_nxt    = sender_r;
    rcpt_nxt      = rcpt_r;
    pos_nxt       = pos_r;
    verb_nxt      = verb_r;
    phase_nxt     = phase_r;
    sfx_idx_nxt   = sfx_idx_r;
    arg_first_nxt = arg_first_r;
    arg_last_nxt  = arg_last_r;
    nonempty_nxt  = nonempty_r;
    multi_nxt     = multi_r;
    nonblank_nxt  = nonblank_r;
    dot_nxt       = dot_r;
    res_valid     = 1'b0;
    res           = '0;
    byte_ok       = 1'b0;
    do_sfx        = 1'b0;
    do_arg        = 1'b0;
    sidx          = sfx_idx_r;
    do_finish     = 1'b0;
    do_eod        = 1'b0;
    cls_fin       = CMD_INVALID;
    path_bad      = 1'b0;
    code          = RC_SYNTAX;

    if (fire && mode_r != MODE_CLOSED) begin
      byte_ok = itm.has_char && (pos_r < POS_W'(MAX_LINE));
      if (byte_ok) begin
        pos_nxt = pos_r + POS_W'(1);
      end

      if (mode_r == MODE_CMD) begin
        // command line parsing
        if (byte_ok) begin
          case (phase_r)
            PH_VERB: begin
              if (itm.is_zero) begin
                phase_nxt = PH_BAD;
              end else begin
                verb_nxt = {verb_r[23:0], itm.up};
                if (pos_r == POS_W'(3)) begin
                  phase_nxt = PH_SEP;
                end
              end
            end
            PH_SEP: begin
              if (itm.is_space) begin
                phase_nxt = PH_SPACES1;
              end else if (itm.is_zero) begin
                phase_nxt = needs_sfx ? PH_BAD : PH_ENDED;
              end else begin
                phase_nxt = PH_BAD;
              end
            end
            PH_SPACES1: begin
              if (itm.is_space) begin
                phase_nxt = PH_SPACES1;
              end else if (itm.is_zero) begin
                phase_nxt = needs_sfx ? PH_BAD : PH_ENDED;
              end else if (needs_sfx) begin
                phase_nxt = PH_SUFFIX;
                sidx      = 3'd0;
                do_sfx    = 1'b1;
              end else begin
                phase_nxt = PH_ARG;
                do_arg    = 1'b1;
              end
            end
            PH_SUFFIX: begin
              do_sfx = 1'b1;
            end
            PH_SPACES2, PH_ARG: begin
              if (itm.is_zero) begin
                phase_nxt = PH_ENDED;
              end else if (!(itm.is_space && phase_r == PH_SPACES2)) begin
                phase_nxt = PH_ARG;
                do_arg    = 1'b1;
              end
            end
            default: begin
            end
          endcase

          // suffix match
          if (do_sfx) begin
            if (sidx < sfx_len && itm.up == sfx_char(cls_cur == CMD_MAIL, sidx)) begin
              sfx_idx_nxt = sidx + 3'd1;
              if (sidx + 3'd1 == sfx_len) begin
                phase_nxt = PH_SPACES2;
              end
            end else begin
              sfx_idx_nxt = sidx;
              phase_nxt   = PH_BAD;
            end
          end

          // argument tracking
          if (do_arg) begin
            if (nonempty_r) begin
              multi_nxt = 1'b1;
            end else begin
              arg_first_nxt = itm.ch;
              nonempty_nxt  = 1'b1;
            end
            arg_last_nxt = itm.ch;
            if (!itm.is_white) begin
              nonblank_nxt = 1'b1;
            end
          end
        end
        do_finish = itm.line_end;
      end else begin
        // message body
        if (byte_ok) begin
          if (dot_r == DOT_LINE_START && itm.is_dot) begin
            if (itm.line_end) begin
              do_eod = 1'b1;
            end else begin
              dot_nxt = DOT_HELD;
            end
          end else begin
            dot_nxt = itm.line_end ? DOT_LINE_START : DOT_IN_LINE;
            if (itm.line_end) begin
              pos_nxt = '0;
            end
            res_valid         = 1'b1;
            res.kind          = 1'b1;
            res.reply_code    = RC_NONE;
            res.command       = CMD_INVALID;
            res.body_byte     = itm.ch;
            res.body_has_byte = 1'b1;
            res.body_line_end = itm.line_end;
          end
        end else if (itm.line_end) begin
          if (dot_r == DOT_HELD) begin
            do_eod = 1'b1;
          end else begin
            dot_nxt           = DOT_LINE_START;
            pos_nxt           = '0;
            res_valid         = 1'b1;
            res.kind          = 1'b1;
            res.reply_code    = RC_NONE;
            res.command       = CMD_INVALID;
            res.body_byte     = CH_NUL;
            res.body_has_byte = 1'b0;
            res.body_line_end = 1'b1;
          end
        end
      end
    end

    // command completion at line end
    if (do_finish) begin
      if (phase_nxt != PH_VERB && phase_nxt != PH_SUFFIX && phase_nxt != PH_BAD) begin
        cls_fin = verb_class(verb_nxt);
        if ((phase_nxt == PH_SEP || phase_nxt == PH_SPACES1) &&
            (cls_fin == CMD_MAIL || cls_fin == CMD_RCPT)) begin
          cls_fin = CMD_INVALID;
        end
      end
      if (!nonempty_nxt) begin
        path_bad = 1'b0;
      end else if (arg_first_nxt == CH_LT) begin
        path_bad = !multi_nxt || (arg_last_nxt != CH_GT);
      end else begin
        path_bad = (arg_first_nxt == CH_GT) || (arg_last_nxt == CH_GT);
      end
      case (cls_fin)
        CMD_NOTIMPL: code = RC_NOTIMPL;
        CMD_NOOP:    code = helo_r ? RC_OK : RC_SEQ;
        CMD_HELO: begin
          if (nonblank_nxt) begin
            helo_nxt = 1'b1;
            code     = RC_OK;
          end else begin
            code = RC_ARG;
          end
        end
        CMD_RSET: begin
          if (!helo_r) begin
            code = RC_SEQ;
          end else if (nonempty_nxt) begin
            code = RC_ARG;
          end else begin
            sender_nxt = 1'b0;
            rcpt_nxt   = 1'b0;
            code       = RC_OK;
          end
        end
        CMD_MAIL: begin
          if (!helo_r) begin
            code = RC_SEQ;
          end else if (path_bad) begin
            code = RC_ARG;
          end else begin
            sender_nxt = 1'b1;
            rcpt_nxt   = 1'b0;
            code       = RC_OK;
          end
        end
        CMD_RCPT: begin
          if (!helo_r || !sender_r) begin
            code = RC_SEQ;
          end else if (path_bad) begin
            code = RC_ARG;
          end else begin
            rcpt_nxt = 1'b1;
            code     = RC_OK;
          end
        end
        CMD_DATA: begin
          if (!helo_r || !sender_r || !rcpt_r) begin
            code = RC_SEQ;
          end else if (nonempty_nxt) begin
            code = RC_ARG;
          end else begin
            mode_nxt = MODE_BODY;
            dot_nxt  = DOT_LINE_START;
            code     = RC_DATA;
          end
        end
        CMD_QUIT: begin
          mode_nxt = MODE_CLOSED;
          code     = RC_BYE;
        end
        default: begin
          cls_fin = CMD_INVALID;
          code    = RC_SYNTAX;
        end
      endcase
      res_valid      = 1'b1;
      res.kind       = 1'b0;
      res.reply_code = code;
      res.command    = cls_fin;
    end

    // end of message data
    if (do_eod) begin
      mode_nxt       = MODE_CMD;
      sender_nxt     = 1'b0;
      rcpt_nxt       = 1'b0;
      dot_nxt        = DOT_LINE_START;
      res_valid      = 1'b1;
      res.kind       = 1'b0;
      res.reply_code = RC_OK;
      res.command    = CMD_DATA;
    end

    // line state cleared after a reply
    if (do_finish || do_eod) begin
      pos_nxt       = '0;
      verb_nxt      = '0;
      phase_nxt     = PH_VERB;
      sfx_idx_nxt   = 3'd0;
      arg_first_nxt = CH_NUL;
      arg_last_nxt  = CH_NUL;
      nonempty_nxt  = 1'b0;
      multi_nxt     = 1'b0;
      nonblank_nxt  = 1'b0;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_CMD;
      helo_r      <= 1'b0;
      sender_r    <= 1'b0;
      rcpt_r      <= 1'b0;
      pos_r       <= '0;
      verb_r      <= '0;
      phase_r     <= PH_VERB;
      sfx_idx_r   <= 3'd0;
      arg_first_r <= CH_NUL;
      arg_last_r  <= CH_NUL;
      nonempty_r  <= 1'b0;
      multi_r     <= 1'b0;
      nonblank_r  <= 1'b0;
      dot_r       <= DOT_LINE_START;
    end else begin
      mode_r      <= mode_nxt;
      helo_r      <= helo_nxt;
      sender_r    <= sender_nxt;
      rcpt_r      <= rcpt_nxt;
      pos_r       <= pos_nxt;
      verb_r      <= verb_nxt;
      phase_r     <= phase_nxt;
      sfx_idx_r   <= sfx_idx_nxt;
      arg_first_r <= arg_first_nxt;
      arg_last_r  <= arg_last_nxt;
      nonempty_r  <= nonempty_nxt;
      multi_r     <= multi_nxt;
      nonblank_r  <= nonblank_nxt;
      dot_r       <= dot_nxt;
    end
  end

endmodule

>>> sv/smtp_seq_outq.sv
// two-entry result queue in front of the result ports
module smtp_seq_outq
  import smtp_seq_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    res_valid,
  input  result_t res,
  output logic    res_room,
  output logic    empty,
  input  logic    pop,
  output result_t head
);

  result_t    mem_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       wr_en, rd_en;

  // pointers and fill count
  assign res_room = (cnt_r != 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign wr_en    = res_valid && res_room;
  assign rd_en    = pop && !empty;
  assign head     = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wr_en ? ~wp_r : wp_r;
    rp_nxt  = rd_en ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // result storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= res;
    end
  end

endmodule

>>> sv/smtp_server_command_sequencer_top.sv
// top level of the smtp command sequencer: front queue, parser back end, result queue
// an item is registered in the front queue, and its result is registered in the result queue ahead of the out_ ports
// throughput: one item per cycle while the result queue has room, set by the combinational parse step in the back end
// an item that yields no result is still taken from the front queue only when the result queue has room
// reset: synchronous active-low rst_n empties both queues, returns to command mode
// and clears the helo, sender and recipient flags
module smtp_server_command_sequencer_top
  import smtp_seq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] in_ch,
  input  logic       in_has_char,
  input  logic       in_line_end,
  input  logic       push,
  output logic       full,
  output logic       out_kind,
  output logic [9:0] out_reply_code,
  output logic [3:0] out_command,
  output logic [7:0] out_body_byte,
  output logic       out_body_has_byte,
  output logic       out_body_line_end,
  output logic       empty,
  input  logic       pop
);

  front_link_t q_head;
  logic        q_ready;
  logic        res_room;
  logic        res_valid;
  result_t     res;
  result_t     out_head;

  // item classification and queue
  smtp_seq_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .in_has_char (in_has_char),
    .in_line_end (in_line_end),
    .push        (push),
    .full        (full),
    .head        (q_head),
    .head_ready  (q_ready)
  );

  // command and body processing
  smtp_seq_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .head_ready (q_ready),
    .res_room   (res_room),
    .res_valid  (res_valid),
    .res        (res)
  );

  // result queue
  smtp_seq_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .res_room  (res_room),
    .empty     (empty),
    .pop       (pop),
    .head      (out_head)
  );

  // result ports
  assign out_kind          = out_head.kind;
  assign out_reply_code    = out_head.reply_code;
  assign out_command       = out_head.command;
  assign out_body_byte     = out_head.body_byte;
  assign out_body_has_byte = out_head.body_has_byte;
  assign out_body_line_end = out_head.body_line_end;

endmodule
